FILE: hdl/rbm_pkg.sv
// Shared constants, mode codes and pipeline types for the RGB blend mode unit.
package rbm_pkg;

	// Fixed point format: ONE = 2^FRAC stands for 1.0
	localparam int FRAC = 15;
	localparam int CW   = FRAC + 1;   // channel value width, holds ONE
	localparam int FW   = 16;         // port field width
	localparam int MW   = 4;          // blend mode width

	localparam logic [CW-1:0] ONE  = {1'b1, {FRAC{1'b0}}};
	localparam logic [CW-1:0] HALF = ONE >> 1;

	// Divider: quotient bits resolved per stage, and stage count
	localparam int DIV_PER = 3;
	localparam int DIV_STG = (FRAC + DIV_PER - 1) / DIV_PER;

	// Total latency: saturate, operands/product, divider stages, combine
	localparam int LAT = DIV_STG + 3;

	// Blend mode codes; unused codes act as softlight
	localparam logic [MW-1:0] MODE_MUL   = 4'd0;
	localparam logic [MW-1:0] MODE_ADD   = 4'd1;
	localparam logic [MW-1:0] MODE_SCR   = 4'd2;
	localparam logic [MW-1:0] MODE_OVL   = 4'd3;
	localparam logic [MW-1:0] MODE_SOFT  = 4'd4;
	localparam logic [MW-1:0] MODE_HARD  = 4'd5;
	localparam logic [MW-1:0] MODE_DODGE = 4'd6;
	localparam logic [MW-1:0] MODE_BURN  = 4'd7;
	localparam logic [MW-1:0] MODE_LDOD  = 4'd8;
	localparam logic [MW-1:0] MODE_LBURN = 4'd9;

	// Per-channel side data carried alongside the divider
	typedef struct packed {
		logic [MW-1:0]   mode;
		logic [CW-1:0]   a;
		logic [CW-1:0]   b;
		logic [2*CW-1:0] p;
		logic [3*CW-1:0] p2;
		logic            fix_en;
		logic [CW-1:0]   fix_val;
	} ch_ctl_t;

endpackage

FILE: hdl/rbm_div.sv
// Pipelined restoring divider: (num << FRAC) / den with num < den.
module rbm_div (
	input  logic                    clk,
	input  logic                    en,
	input  logic [rbm_pkg::CW-1:0]  num,
	input  logic [rbm_pkg::CW-1:0]  den,
	output logic [rbm_pkg::FRAC-1:0] q
);

	logic [rbm_pkg::CW-1:0]   rem_s [rbm_pkg::DIV_STG];
	logic [rbm_pkg::CW-1:0]   den_s [rbm_pkg::DIV_STG];
	logic [rbm_pkg::FRAC-1:0] quo_s [rbm_pkg::DIV_STG];

	for (genvar g = 0; g < rbm_pkg::DIV_STG; g++) begin : g_stg
		logic [rbm_pkg::CW-1:0]   rem_in, den_in, rem_nxt;
		logic [rbm_pkg::FRAC-1:0] quo_in, quo_nxt;

		if (g == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_s[g-1];
			assign den_in = den_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		// A few shift-subtract steps, one quotient bit each
		always_comb begin
			logic [rbm_pkg::CW:0] r2;
			r2      = '0;
			rem_nxt = rem_in;
			quo_nxt = quo_in;
			for (int j = 0; j < rbm_pkg::DIV_PER; j++) begin
				if (g * rbm_pkg::DIV_PER + j < rbm_pkg::FRAC) begin
					r2 = {rem_nxt, 1'b0};
					if (r2 >= {1'b0, den_in}) begin
						rem_nxt = rbm_pkg::CW'(r2 - {1'b0, den_in});
						quo_nxt = {quo_nxt[rbm_pkg::FRAC-2:0], 1'b1};
					end else begin
						rem_nxt = rbm_pkg::CW'(r2);
						quo_nxt = {quo_nxt[rbm_pkg::FRAC-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nxt;
				den_s[g] <= den_in;
				quo_s[g] <= quo_nxt;
			end
		end
	end

	assign q = quo_s[rbm_pkg::DIV_STG-1];

endmodule

FILE: hdl/rbm_channel.sv
// One color channel blend pipeline: saturate, multiply, divide, combine.
module rbm_channel (
	input  logic                   clk,
	input  logic                   en,
	input  logic [rbm_pkg::MW-1:0] mode,
	input  logic [rbm_pkg::FW-1:0] a_in,
	input  logic [rbm_pkg::FW-1:0] b_in,
	output logic [rbm_pkg::FW-1:0] res
);

	localparam int CW = rbm_pkg::CW;
	localparam logic [rbm_pkg::FW:0] ONE_X = (rbm_pkg::FW + 1)'(rbm_pkg::ONE);

	logic [CW-1:0]          a_s1, b_s1;
	logic [rbm_pkg::MW-1:0] mode_s1;
	logic [CW-1:0]          a_sat, b_sat;

	// Saturate inputs to one
	always_comb begin
		a_sat = ({1'b0, a_in} > ONE_X) ? rbm_pkg::ONE : CW'({1'b0, a_in});
		b_sat = ({1'b0, b_in} > ONE_X) ? rbm_pkg::ONE : CW'({1'b0, b_in});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_sat;
			b_s1    <= b_sat;
			mode_s1 <= mode;
		end
	end

	// Operand selection for the product and the divider
	logic [CW-1:0] op_x, op_y, b_dev, dval, dnum, dden, fval;
	logic          above, fen;

	always_comb begin
		above = a_s1 > rbm_pkg::HALF;
		b_dev = (b_s1 >= rbm_pkg::HALF) ? b_s1 - rbm_pkg::HALF : rbm_pkg::HALF - b_s1;
		dval  = rbm_pkg::HALF - b_dev;
		op_x  = a_s1;
		op_y  = b_s1;
		dnum  = '0;
		dden  = CW'(1);
		fen   = 1'b0;
		fval  = '0;
		unique case (mode_s1)
			rbm_pkg::MODE_MUL, rbm_pkg::MODE_SCR, rbm_pkg::MODE_ADD,
			rbm_pkg::MODE_LDOD, rbm_pkg::MODE_LBURN: begin
				op_x = a_s1;
				op_y = b_s1;
			end
			rbm_pkg::MODE_OVL: begin
				if (b_s1 >= rbm_pkg::HALF) begin
					op_x = rbm_pkg::ONE - a_s1;
					op_y = rbm_pkg::ONE - b_s1;
				end
			end
			rbm_pkg::MODE_HARD: begin
				if (above) begin
					op_x = rbm_pkg::ONE - b_s1;
					op_y = a_s1 - rbm_pkg::HALF;
				end
			end
			rbm_pkg::MODE_DODGE: begin
				// quotient reaches one whenever b >= one - a
				if (b_s1 >= rbm_pkg::ONE - a_s1) begin
					fen  = 1'b1;
					fval = rbm_pkg::ONE;
				end else begin
					dnum = b_s1;
					dden = rbm_pkg::ONE - a_s1;
				end
			end
			rbm_pkg::MODE_BURN: begin
				if (a_s1 == rbm_pkg::ONE) begin
					fen  = 1'b1;
					fval = rbm_pkg::ONE;
				end else if (a_s1 == '0 || (rbm_pkg::ONE - b_s1) >= a_s1) begin
					fen  = 1'b1;
					fval = '0;
				end else begin
					dnum = rbm_pkg::ONE - b_s1;
					dden = a_s1;
				end
			end
			default: begin
				// softlight
				op_x = above ? rbm_pkg::ONE - b_s1 : b_s1;
				op_y = above ? CW'({a_s1 - rbm_pkg::HALF, 1'b0})
				             : CW'({rbm_pkg::HALF - a_s1, 1'b0});
			end
		endcase
	end

	rbm_pkg::ch_ctl_t       ctl_nxt;
	rbm_pkg::ch_ctl_t       ctl_s2;
	logic [CW-1:0]          d_s2, num_s2, den_s2;

	// Side data for the item, with the first product
	always_comb begin
		ctl_nxt         = '0;
		ctl_nxt.mode    = mode_s1;
		ctl_nxt.a       = a_s1;
		ctl_nxt.b       = b_s1;
		ctl_nxt.p       = op_x * op_y;
		ctl_nxt.fix_en  = fen;
		ctl_nxt.fix_val = fval;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_nxt;
			d_s2   <= dval;
			num_s2 <= dnum;
			den_s2 <= dden;
		end
	end

	// Divider runs alongside the side data
	logic [rbm_pkg::FRAC-1:0] quo;

	rbm_div u_div (
		.clk (clk),
		.en  (en),
		.num (num_s2),
		.den (den_s2),
		.q   (quo)
	);

	rbm_pkg::ch_ctl_t hold_s [rbm_pkg::DIV_STG];
	rbm_pkg::ch_ctl_t hold_in;

	// Second product for softlight in the first hold stage, then carry
	always_comb begin
		hold_in    = ctl_s2;
		hold_in.p2 = ctl_s2.p * d_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hold_s[0] <= hold_in;
			for (int i = 1; i < rbm_pkg::DIV_STG; i++) begin
				hold_s[i] <= hold_s[i-1];
			end
		end
	end

	// Final combine per mode
	rbm_pkg::ch_ctl_t h;
	logic [CW:0]      sum, p_sh, p_sh1, p2_sh, r;

	always_comb begin
		h     = hold_s[rbm_pkg::DIV_STG-1];
		sum   = {1'b0, h.a} + {1'b0, h.b};
		p_sh  = (CW+1)'(h.p >> rbm_pkg::FRAC);
		p_sh1 = (CW+1)'(h.p >> (rbm_pkg::FRAC - 1));
		p2_sh = (CW+1)'(h.p2 >> (2 * rbm_pkg::FRAC));
		unique case (h.mode)
			rbm_pkg::MODE_MUL: r = p_sh;
			rbm_pkg::MODE_ADD, rbm_pkg::MODE_LDOD:
				r = (sum > {1'b0, rbm_pkg::ONE}) ? {1'b0, rbm_pkg::ONE} : sum;
			rbm_pkg::MODE_SCR: r = sum - p_sh;
			rbm_pkg::MODE_OVL:
				r = (h.b < rbm_pkg::HALF) ? p_sh1 : {1'b0, rbm_pkg::ONE} - p_sh1;
			rbm_pkg::MODE_HARD:
				r = (h.a > rbm_pkg::HALF) ? {1'b0, h.b} + p_sh1 : p_sh1;
			rbm_pkg::MODE_DODGE:
				r = h.fix_en ? {1'b0, h.fix_val} : (CW+1)'(quo);
			rbm_pkg::MODE_BURN:
				r = h.fix_en ? {1'b0, h.fix_val}
				             : {1'b0, rbm_pkg::ONE} - (CW+1)'(quo);
			rbm_pkg::MODE_LBURN:
				r = (sum < {1'b0, rbm_pkg::ONE}) ? '0 : sum - {1'b0, rbm_pkg::ONE};
			default:
				r = (h.a > rbm_pkg::HALF) ? {1'b0, h.b} + p2_sh : {1'b0, h.b} - p2_sh;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= rbm_pkg::FW'(r);
		end
	end

endmodule

FILE: hdl/rgb_blend_mode_unit.sv
// Top level: stream ports, mode register, valid/alpha pipeline, three channels.
// Pipeline: saturate, product, five-stage divider and combine registers.
// Throughput: one item per clock; the whole pipe holds while a result waits.
// Reset: arst_n clears all valid bits and sets the blend mode to softlight.
// No clearing pass; the block accepts items as soon as reset is released.
module rgb_blend_mode_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [63:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata
);

	localparam int FW = rbm_pkg::FW;

	logic [rbm_pkg::MW-1:0] mode_q;
	logic                   en;
	logic                   vld_s   [rbm_pkg::LAT];
	logic [FW-1:0]          alpha_s [rbm_pkg::LAT];
	logic [FW-1:0]          res_red, res_green, res_blue;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rbm_pkg::MODE_SOFT;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Pipe advances unless the last stage holds an untaken item
	assign en            = !vld_s[rbm_pkg::LAT-1] || m_axis_tready;
	assign s_axis_tready = en;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbm_pkg::LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < rbm_pkg::LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Alpha passes through unchanged
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s[0] <= s_axis_tdata[63:48];
			for (int i = 1; i < rbm_pkg::LAT; i++) begin
				alpha_s[i] <= alpha_s[i-1];
			end
		end
	end

	rbm_channel u_red (
		.clk  (clk),
		.en   (en),
		.mode (mode_q),
		.a_in (s_axis_tdata[15:0]),
		.b_in (s_axis_tdata[79:64]),
		.res  (res_red)
	);

	rbm_channel u_green (
		.clk  (clk),
		.en   (en),
		.mode (mode_q),
		.a_in (s_axis_tdata[31:16]),
		.b_in (s_axis_tdata[95:80]),
		.res  (res_green)
	);

	rbm_channel u_blue (
		.clk  (clk),
		.en   (en),
		.mode (mode_q),
		.a_in (s_axis_tdata[47:32]),
		.b_in (s_axis_tdata[111:96]),
		.res  (res_blue)
	);

	assign m_axis_tvalid = vld_s[rbm_pkg::LAT-1];
	assign m_axis_tdata  = {alpha_s[rbm_pkg::LAT-1], res_blue, res_green, res_red};

endmodule
